// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of the block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHEN_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CHEN_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/chen_pkg.sv =====
// Shared constants, types and helper functions of the hash embedding normalizer.
// No dependencies; compile first.
package chen_pkg;

  localparam int DIM_DEFAULT = 64;

  // Field widths
  localparam int CODE_W    = 8;
  localparam int BIN_IDX_W = 6;
  localparam int VAL_W     = 16;
  localparam int CNT_W     = 16;

  // Hash constants
  localparam int          HASH_W     = 32;
  localparam logic [31:0] HASH_MUL   = 32'h9E37_79B1;
  localparam logic [31:0] HASH_MIX   = 32'h9E37_79B9;
  localparam int          HASH_STEPS = HASH_W / CODE_W;

  // Normalization unit
  localparam int          QUO_W      = 31;
  localparam int          SQRT_STEPS = 16;
  localparam int          STEP_W     = 5;
  localparam int          ROOT_W     = 32;
  localparam logic [31:0] ROOT_ONE   = 32'h4000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_RD1,
    ST_WR1,
    ST_RD2,
    ST_WR2,
    ST_SUM,
    ST_SUM_TAIL,
    ST_EMIT_RD,
    ST_EMIT_LATCH,
    ST_EMIT_CALC,
    ST_EMIT_PUT,
    ST_CLEAR
  } state_t;

  typedef enum logic [1:0] {
    N_IDLE,
    N_SQR,
    N_DIV,
    N_SQRT
  } norm_state_t;

  // Saturating count update
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [1:0] amt);
    logic [CNT_W:0] s;
    s = {1'b0, c} + {{(CNT_W-1){1'b0}}, amt};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/chen_in_if.sv =====
// Character input channel: valid/ready handshake with the character payload.
// No dependencies.
interface chen_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_valid;
  logic       end_of_text;

  modport source (output valid, output char_code, output char_valid,
                  output end_of_text, input ready);
  modport sink   (input valid, input char_code, input char_valid,
                  input end_of_text, output ready);
endinterface

// ===== hw/rtl/chen_out_if.sv =====
// Embedding output channel: valid/ready handshake with one vector element.
// No dependencies.
interface chen_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  bin_index;
  logic [15:0] bin_value;
  logic        last_value;

  modport source (output valid, output bin_index, output bin_value,
                  output last_value, input ready);
  modport sink   (input valid, input bin_index, input bin_value,
                  input last_value, output ready);
endinterface

// ===== hw/rtl/char_hash_embedding_normalizer_top.sv =====
// Character hash embedding normalizer, top level.
// Depends on chen_pkg, chen_in_if, chen_out_if, chen_ram and chen_norm.
//
// Each accepted character is hashed into two of DIM saturating 16-bit bins
// kept in one RAM; a character is accepted, reduced modulo DIM in four byte
// steps, then each bin is read, modified and written in turn, and an item
// without a character and without end of text is accepted and ignored.
// On end of text the block sums the squares of all bins, then emits one
// Q1.15 element per bin in ascending order. A nonzero bin is normalized by
// the bit-serial divider and square root of the normalization unit; a zero
// bin, or a vector whose bins are all zero, bypasses that unit and yields 0.
// After the last element the bins and the character position are cleared.
// A new item is taken while the final element still waits on the output.
module char_hash_embedding_normalizer_top #(
  parameter int DIM = chen_pkg::DIM_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  chen_in_if.sink           char_in,
  chen_out_if.source        vec_out
);
  import chen_pkg::*;

  localparam int IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int SUM_W = 2 * CNT_W + IDX_W;
  localparam logic [IDX_W:0]   DIM_W  = (IDX_W+1)'(DIM);
  localparam logic [IDX_W-1:0] LAST_K = IDX_W'(DIM - 1);

  state_t             state, state_next;
  logic [HASH_W-1:0]  prod;
  logic [HASH_W-1:0]  h_a, h_b;
  logic [IDX_W-1:0]   r_a, r_b;
  logic [1:0]         hcnt;
  logic               eot;
  logic [DIM-1:0]     vld;
  logic               rd_vld;
  logic [IDX_W-1:0]   k;
  logic               p1, p2;
  logic [2*CNT_W-1:0] sq;
  logic [SUM_W-1:0]   acc;
  logic [VAL_W-1:0]   q_val;

  logic               out_valid;
  logic [BIN_IDX_W-1:0] out_idx;
  logic [VAL_W-1:0]   out_val;
  logic               out_last;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [CNT_W-1:0]   ram_wdata, ram_rdata;
  logic [CNT_W-1:0]   cur;

  logic               norm_start, norm_done;
  logic [VAL_W-1:0]   norm_q;

  logic               in_fire, out_free;
  logic [HASH_W-1:0]  h_in;

  // Fold one byte into a running remainder modulo DIM, MSB first
  function automatic logic [IDX_W-1:0] mod_byte(input logic [IDX_W-1:0] r,
                                                input logic [7:0] b);
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] acc_r;
    acc_r = r;
    for (int i = 7; i >= 0; i--) begin
      t = {acc_r, b[i]};
      if (t >= DIM_W) begin
        t = t - DIM_W;
      end
      acc_r = t[IDX_W-1:0];
    end
    return acc_r;
  endfunction

  assign in_fire  = char_in.valid && char_in.ready;
  assign out_free = !out_valid || vec_out.ready;
  assign h_in     = {{(HASH_W-CODE_W){char_in.char_code[CODE_W-1]}}, char_in.char_code}
                    ^ prod;
  assign cur      = rd_vld ? ram_rdata : '0;

  assign char_in.ready      = state == ST_IDLE;
  assign vec_out.valid      = out_valid;
  assign vec_out.bin_index  = out_idx;
  assign vec_out.bin_value  = out_val;
  assign vec_out.last_value = out_last;

  chen_ram #(
    .WIDTH(CNT_W),
    .DEPTH(DIM)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  chen_norm #(
    .SUM_W(SUM_W)
  ) u_norm (
    .clk  (clk),
    .rst  (rst),
    .start(norm_start),
    .cnt  (cur),
    .sumsq(acc),
    .done (norm_done),
    .q    (norm_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM port control
  always_comb begin
    state_next = state;
    ram_raddr  = k;
    ram_we     = 1'b0;
    ram_waddr  = r_a;
    ram_wdata  = sat_add(cur, 2'd2);
    norm_start = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (char_in.char_valid) begin
            state_next = ST_HASH;
          end else if (char_in.end_of_text) begin
            state_next = ST_SUM;
          end
        end
      end
      ST_HASH: begin
        if (hcnt == 2'(HASH_STEPS - 1)) state_next = ST_RD1;
      end
      ST_RD1: begin
        ram_raddr  = r_a;
        state_next = ST_WR1;
      end
      ST_WR1: begin
        ram_we     = 1'b1;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        ram_raddr  = r_b;
        state_next = ST_WR2;
      end
      ST_WR2: begin
        ram_we     = 1'b1;
        ram_waddr  = r_b;
        ram_wdata  = sat_add(cur, 2'd1);
        state_next = eot ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (k == LAST_K) state_next = ST_SUM_TAIL;
      end
      ST_SUM_TAIL: begin
        if (!p1 && !p2) state_next = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LATCH;
      end
      ST_EMIT_LATCH: begin
        if (acc == '0 || cur == '0) begin
          state_next = ST_EMIT_PUT;
        end else begin
          norm_start = 1'b1;
          state_next = ST_EMIT_CALC;
        end
      end
      ST_EMIT_CALC: begin
        if (norm_done) state_next = ST_EMIT_PUT;
      end
      ST_EMIT_PUT: begin
        if (out_free) state_next = (k == LAST_K) ? ST_CLEAR : ST_EMIT_RD;
      end
      ST_CLEAR: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers: position, bin valid bits, sweep counter, accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      prod      <= '0;
      vld       <= '0;
      k         <= '0;
      hcnt      <= '0;
      p1        <= 1'b0;
      p2        <= 1'b0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      p1 <= state == ST_SUM;
      p2 <= p1;
      if (p2) begin
        acc <= acc + SUM_W'(sq);
      end
      // Load a new transaction or drop the accepted one
      if (state == ST_EMIT_PUT && out_free) begin
        out_valid <= 1'b1;
      end else if (vec_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          hcnt <= '0;
        end
        ST_HASH: begin
          hcnt <= hcnt + 1'b1;
        end
        ST_WR1: begin
          vld[r_a] <= 1'b1;
        end
        ST_WR2: begin
          vld[r_b] <= 1'b1;
          prod     <= prod + HASH_MUL;
        end
        ST_SUM: begin
          k <= (k == LAST_K) ? '0 : k + 1'b1;
        end
        ST_EMIT_PUT: begin
          if (out_free) begin
            k <= (k == LAST_K) ? '0 : k + 1'b1;
          end
        end
        ST_CLEAR: begin
          vld  <= '0;
          prod <= '0;
          acc  <= '0;
        end
        default: begin
          hcnt <= hcnt;
        end
      endcase
    end
  end

  // Payload registers: hash words, remainders, squares, result word
  always_ff @(posedge clk) begin
    rd_vld <= vld[ram_raddr];
    if (p1) begin
      sq <= cur * cur;
    end
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          h_a <= h_in;
          h_b <= h_in ^ HASH_MIX;
          r_a <= '0;
          r_b <= '0;
          eot <= char_in.end_of_text;
        end
      end
      ST_HASH: begin
        r_a <= mod_byte(r_a, h_a[HASH_W-1 -: CODE_W]);
        r_b <= mod_byte(r_b, h_b[HASH_W-1 -: CODE_W]);
        h_a <= h_a << CODE_W;
        h_b <= h_b << CODE_W;
      end
      ST_EMIT_LATCH: begin
        q_val <= '0;
      end
      ST_EMIT_CALC: begin
        if (norm_done) q_val <= norm_q;
      end
      ST_EMIT_PUT: begin
        if (out_free) begin
          out_idx  <= BIN_IDX_W'(k);
          out_val  <= q_val;
          out_last <= k == LAST_K;
        end
      end
      default: begin
        eot <= eot;
      end
    endcase
  end

endmodule

// ===== hw/rtl/chen_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module chen_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/chen_norm.sv =====
// Normalization unit: q = floor(sqrt(floor(c^2 * 2^30 / S))), one bit a cycle.
// Depends on chen_pkg.
module chen_norm #(
  parameter int SUM_W = 38
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [chen_pkg::CNT_W-1:0] cnt,
  input  logic [SUM_W-1:0]          sumsq,
  output logic                      done,
  output logic [chen_pkg::VAL_W-1:0] q
);
  import chen_pkg::*;

  norm_state_t         state, state_next;
  logic [STEP_W-1:0]   step;
  logic [CNT_W-1:0]    cnt_q;
  logic [SUM_W-1:0]    s_q;
  logic [SUM_W:0]      rem;
  logic [QUO_W-1:0]    quo;
  logic [ROOT_W-1:0]   op, res, one;

  logic [2*CNT_W-1:0]  sq;
  logic                ge;
  logic [SUM_W:0]      rem_sub;
  logic [ROOT_W-1:0]   trial;
  logic                take;
  logic [ROOT_W-1:0]   res_next;
  logic                div_last, sqrt_last;

  // Divide step compares and subtracts; root step tests the trial value
  assign sq        = cnt_q * cnt_q;
  assign ge        = rem >= {1'b0, s_q};
  assign rem_sub   = ge ? (rem - {1'b0, s_q}) : rem;
  assign trial     = res + one;
  assign take      = op >= trial;
  assign res_next  = take ? ((res >> 1) + one) : (res >> 1);
  assign div_last  = step == STEP_W'(QUO_W - 1);
  assign sqrt_last = step == STEP_W'(SQRT_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == N_SQRT) && sqrt_last;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      N_IDLE: if (start) state_next = N_SQR;
      N_SQR:  state_next = N_DIV;
      N_DIV:  if (div_last) state_next = N_SQRT;
      N_SQRT: if (sqrt_last) state_next = N_IDLE;
      default: state_next = N_IDLE;
    endcase
  end

  // Datapath: latch operands, square, divide, then take the root
  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        if (start) begin
          cnt_q <= cnt;
          s_q   <= sumsq;
        end
      end
      N_SQR: begin
        rem  <= (SUM_W+1)'(sq);
        step <= '0;
      end
      N_DIV: begin
        rem  <= {rem_sub[SUM_W-1:0], 1'b0};
        quo  <= {quo[QUO_W-2:0], ge};
        step <= div_last ? '0 : step + 1'b1;
        if (div_last) begin
          op   <= ROOT_W'({quo[QUO_W-2:0], ge});
          res  <= '0;
          one  <= ROOT_ONE;
        end
      end
      N_SQRT: begin
        if (take) begin
          op <= op - trial;
        end
        res  <= res_next;
        one  <= one >> 2;
        step <= step + 1'b1;
        if (sqrt_last) begin
          q <= res_next[VAL_W-1:0];
        end
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/chen_checker.sv =====
// Port-level checker for the hash embedding normalizer, bound to the top level.
// Depends on assert_macros.svh and chen_pkg.
`include "assert_macros.svh"

module chen_checker #(
  parameter int DIM = chen_pkg::DIM_DEFAULT
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [chen_pkg::BIN_IDX_W-1:0] out_bin_index,
  input logic [chen_pkg::VAL_W-1:0]    out_bin_value,
  input logic                          out_last_value
);
  import chen_pkg::*;

  localparam logic [BIN_IDX_W-1:0] LAST_IDX = BIN_IDX_W'(DIM - 1);
  localparam logic [VAL_W-1:0]     ONE_Q15  = VAL_W'(32768);

  logic [BIN_IDX_W-1:0] exp_idx;

  // Track the index the next element must carry
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx <= out_last_value ? '0 : exp_idx + 1'b1;
    end
  end

  `CHEN_ASSERT_NOW(a_idx_order, clk, rst, out_valid, out_bin_index == exp_idx, "element out of order")
  `CHEN_ASSERT_NOW(a_last_flag, clk, rst, out_valid, out_last_value == (out_bin_index == LAST_IDX), "last flag mismatch")
  `CHEN_ASSERT_NOW(a_value_range, clk, rst, out_valid, out_bin_value <= ONE_Q15, "element above 1.0")
  `CHEN_ASSERT_NOW(a_no_input_mid_vector, clk, rst, out_valid && !out_last_value, !in_ready, "input taken during emit")
  `CHEN_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_bin_value) && $stable(out_bin_index), "stalled transaction changed")

endmodule

bind char_hash_embedding_normalizer_top chen_checker #(
  .DIM(DIM)
) u_chen_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (char_in.ready),
  .out_valid     (vec_out.valid),
  .out_ready     (vec_out.ready),
  .out_bin_index (vec_out.bin_index),
  .out_bin_value (vec_out.bin_value),
  .out_last_value(vec_out.last_value)
);
